@@ rtl/core/mexp_pkg.sv @@
// Package for the modular exponentiation block.
// Holds the sequencer state type, the word width and the register indexes.
// No dependencies.
package mexp_pkg;

  localparam int VALUE_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_FINISH
  } mexp_state_e;

endpackage

@@ rtl/core/mexp_msg_if.sv @@
// Input channel of the modular exponentiation block: one message word.
// Depends on mexp_pkg.
interface mexp_msg_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::VALUE_W-1:0] message_value;

  modport source (output valid, output message_value, input ready);
  modport sink   (input valid, input message_value, output ready);
endinterface

@@ rtl/core/mexp_res_if.sv @@
// Output channel of the modular exponentiation block: one result word.
// Depends on mexp_pkg.
interface mexp_res_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::VALUE_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

@@ rtl/core/modular_exponentiation.sv @@
// Modular exponentiation top level: message_value^exponent mod modulus.
// Depends on mexp_pkg, mexp_msg_if and mexp_res_if.
//
// One word at a time: the block takes a message word only when idle and
// returns one result word per message. A single shift-add-reduce unit
// processes one operand bit per cycle and does all the arithmetic. The base
// is first reduced modulo the modulus; then each exponent bit, lowest first,
// takes a multiply into the accumulator when the bit is set and a squaring
// of the base, and the loop ends once no set exponent bit remains.
// A modulus of zero returns 0. The finished result sits in an output
// register until taken. Operands and registers use their low WORD_BITS
// bits; writes to an unknown index are dropped. Write the registers only
// while the block is idle.
module modular_exponentiation #(
  parameter int WORD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mexp_pkg::VALUE_W-1:0]   cfg_data_i,
  mexp_msg_if.sink                       msg_i,
  mexp_res_if.source                     res_o
);

  localparam int W     = WORD_BITS;
  localparam int CNT_W = $clog2(WORD_BITS);

  mexp_pkg::mexp_state_e state_q, state_d;

  logic [W-1:0]     exp_q;
  logic [W-1:0]     mod_q;
  logic [W:0]       mod2_q;
  logic [W-1:0]     e_q;
  logic [W-1:0]     base_q;
  logic [W-1:0]     acc_q;
  logic [W-1:0]     a_q;
  logic [W-1:0]     b_q;
  logic [W-1:0]     r_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [W-1:0]     out_data_q;

  logic             in_ready;
  logic             out_load;
  logic [W-1:0]     addend;
  logic [W+1:0]     t_sum;
  logic [W+1:0]     t_sub1;
  logic [W+1:0]     t_sub2;
  logic [W-1:0]     unit_res;
  logic             in_accept;
  logic             step_last;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (msg_i.valid) begin
          state_d = (mod_q == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_MUL_ACC, mexp_pkg::ST_SQUARE: begin
        if (step_last) state_d = mexp_pkg::ST_EXP;
      end
      mexp_pkg::ST_EXP: begin
        if (e_q == '0) begin
          state_d = mexp_pkg::ST_FINISH;
        end else if (e_q[0]) begin
          state_d = mexp_pkg::ST_MUL_ACC;
        end else begin
          state_d = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid_q || res_o.ready) state_d = mexp_pkg::ST_IDLE;
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    addend   = '0;
    case (state_q)
      mexp_pkg::ST_IDLE:    in_ready = 1'b1;
      mexp_pkg::ST_REDUCE:  addend = {{(W-1){1'b0}}, b_q[W-1]};
      mexp_pkg::ST_MUL_ACC,
      mexp_pkg::ST_SQUARE:  addend = b_q[W-1] ? a_q : '0;
      mexp_pkg::ST_FINISH:  out_load = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign in_accept = msg_i.valid && in_ready;
  assign step_last = (cnt_q == '0);

  // Shared unit: r = (2r + addend) mod m, with 2r + addend below 3m
  assign t_sum  = {1'b0, r_q, 1'b0} + {2'b00, addend};
  assign t_sub1 = t_sum - {2'b00, mod_q};
  assign t_sub2 = t_sum - {1'b0, mod2_q};

  always_comb begin
    if (t_sum >= {1'b0, mod2_q}) begin
      unit_res = t_sub2[W-1:0];
    end else if (t_sum >= {2'b00, mod_q}) begin
      unit_res = t_sub1[W-1:0];
    end else begin
      unit_res = t_sum[W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      exp_q       <= '0;
      mod_q       <= {{(W-1){1'b0}}, 1'b1};
      mod2_q      <= {{(W-1){1'b0}}, 2'b10};
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mexp_pkg::REG_EXPONENT: exp_q <= cfg_data_i[W-1:0];
          mexp_pkg::REG_MODULUS: begin
            mod_q  <= cfg_data_i[W-1:0];
            mod2_q <= {cfg_data_i[W-1:0], 1'b0};
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_q   <= exp_q;
      b_q   <= msg_i.message_value[W-1:0];
      r_q   <= '0;
      cnt_q <= CNT_W'(W - 1);
      acc_q <= {{(W-1){1'b0}}, (mod_q > {{(W-1){1'b0}}, 1'b1})};
    end
    case (state_q)
      mexp_pkg::ST_EXP: begin
        a_q   <= e_q[0] ? acc_q : base_q;
        b_q   <= base_q;
        r_q   <= '0;
        cnt_q <= CNT_W'(W - 1);
      end
      mexp_pkg::ST_REDUCE, mexp_pkg::ST_MUL_ACC, mexp_pkg::ST_SQUARE: begin
        r_q   <= unit_res;
        b_q   <= {b_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (step_last) begin
          if (state_q == mexp_pkg::ST_MUL_ACC) begin
            acc_q <= unit_res;
            e_q   <= {e_q[W-1:1], 1'b0};
          end else if (state_q == mexp_pkg::ST_SQUARE) begin
            base_q <= unit_res;
            e_q    <= {1'b0, e_q[W-1:1]};
          end else begin
            base_q <= unit_res;
          end
        end
      end
      default: ;
    endcase
    if (out_load) out_data_q <= acc_q;
  end

  assign msg_i.ready        = in_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.power_result = mexp_pkg::VALUE_W'(out_data_q);

endmodule
